// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SAD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SAD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAD_ASSERT(lbl, clk, rst, prop, msg)
`define SAD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/sad_pkg.sv =====
// Types, constants and atmosphere tables for the air data pipeline.
`timescale 1ns / 1ps
package sad_pkg;

  localparam int TABLE_POINTS = 21;
  localparam int AFB = 8;
  localparam int IDX_W = $clog2(TABLE_POINTS);
  localparam logic [12:0] ALT_TOP = 13'((TABLE_POINTS - 1) << AFB);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(TABLE_POINTS - 1);

  localparam logic [1:0] ACT_GIVEN = 2'd1;
  localparam logic [1:0] ACT_MACH = 2'd2;
  localparam logic [1:0] STAT_GIVEN = 2'd0;
  localparam logic [1:0] STAT_MACH = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  localparam logic [14:0] TAB_TEMP [TABLE_POINTS] = '{
    15'd18442, 15'd18026, 15'd17610, 15'd17194, 15'd16778, 15'd16362, 15'd15946,
    15'd15530, 15'd15114, 15'd14698, 15'd14282, 15'd13866, 15'd13866, 15'd13866,
    15'd13866, 15'd13866, 15'd13866, 15'd13866, 15'd13866, 15'd13866, 15'd13866};
  localparam logic [15:0] TAB_PRESS [TABLE_POINTS] = '{
    16'd41503, 16'd36813, 16'd32563, 16'd28722, 16'd25256, 16'd22138, 16'd19340,
    16'd16837, 16'd14603, 16'd12616, 16'd10854, 16'd9298, 16'd7946, 16'd6791,
    16'd5804, 16'd4961, 16'd4241, 16'd3625, 16'd3099, 16'd2649, 16'd2265};
  localparam logic [14:0] TAB_DENS [TABLE_POINTS] = '{
    15'd20070, 15'd18214, 15'd16490, 15'd14895, 15'd13420, 15'd12060, 15'd10809,
    15'd9658, 15'd8615, 15'd7653, 15'd6775, 15'd5977, 15'd5110, 15'd4368,
    15'd3734, 15'd3192, 15'd2728, 15'd2331, 15'd1994, 15'd1704, 15'd1457};

  localparam logic [14:0] TEMP_TOP = TAB_TEMP[TABLE_POINTS-1];

  typedef struct packed {
    logic [AFB-1:0] frac;
    logic [14:0]    t0;
    logic [14:0]    t1;
    logic [15:0]    p0;
    logic [15:0]    p1;
    logic [14:0]    d0;
    logic [14:0]    d1;
    logic [14:0]    temp;
    logic [15:0]    press;
    logic [14:0]    dens;
    logic [31:0]    rem;
    logic [31:0]    res;
    logic [30:0]    sbit;
    logic [33:0]    acc;
    logic [12:0]    sound;
    logic [1:0]     action;
    logic [16:0]    given;
    logic [15:0]    mach;
    logic           clamped;
  } pipe_t;

  // (y0*(1-f) + y1*f) with round half up
  function automatic logic [15:0] interp(input logic [15:0] y0, input logic [15:0] y1,
                                         input logic [AFB-1:0] f);
    logic [AFB:0] omf;
    logic [AFB+16:0] sum;
    omf = (AFB+1)'(1 << AFB) - {1'b0, f};
    sum = ({{(AFB+1){1'b0}}, y0} * {16'd0, omf}) + ({{(AFB+1){1'b0}}, y1} * {17'd0, f})
        + (AFB+17)'(1 << (AFB - 1));
    return sum[AFB+15:AFB];
  endfunction

endpackage

// ===== rtl/sad_lookup.sv =====
// Altitude clamp, table lookup and linear interpolation (two stages).
`timescale 1ns / 1ps
module sad_lookup import sad_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [12:0] altitude,
  input  logic [1:0]  action,
  input  logic [16:0] speed_given,
  input  logic [15:0] mach,
  output logic        out_valid,
  input  logic        out_ready,
  output pipe_t       out_d
);

  logic va, vb, rdy_a, rdy_b;
  pipe_t da, db, da_next, db_next;
  logic [12:0] alt_c;
  logic [IDX_W-1:0] idx, idx1;

  assign rdy_b = !vb || out_ready;
  assign rdy_a = !va || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    alt_c = (altitude > ALT_TOP) ? ALT_TOP : altitude;
    idx = alt_c[12:AFB];
    idx1 = (idx == IDX_TOP) ? idx : idx + IDX_W'(1);
    da_next = '0;
    da_next.frac = alt_c[AFB-1:0];
    da_next.t0 = TAB_TEMP[idx];
    da_next.t1 = TAB_TEMP[idx1];
    da_next.p0 = TAB_PRESS[idx];
    da_next.p1 = TAB_PRESS[idx1];
    da_next.d0 = TAB_DENS[idx];
    da_next.d1 = TAB_DENS[idx1];
    da_next.action = action;
    da_next.given = speed_given;
    da_next.mach = mach;
    da_next.clamped = (altitude > ALT_TOP);
  end

  always_comb begin
    db_next = da;
    db_next.temp = 15'(interp({1'b0, da.t0}, {1'b0, da.t1}, da.frac));
    db_next.press = interp(da.p0, da.p1, da.frac);
    db_next.dens = 15'(interp({1'b0, da.d0}, {1'b0, da.d1}, da.frac));
    // sqrt(temp * 65536) starts here
    db_next.rem = {1'b0, db_next.temp, 16'd0};
    db_next.res = '0;
    db_next.sbit = 31'(1) << 30;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) da <= da_next;
    if (rdy_b && va) db <= db_next;
  end

  assign out_valid = vb;
  assign out_d = db;

endmodule

// ===== rtl/sad_sqrt.sv =====
// One square root stage: four result bits per register stage.
`timescale 1ns / 1ps
module sad_sqrt import sad_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  pipe_t in_d,
  output logic  out_valid,
  input  logic  out_ready,
  output pipe_t out_d
);

  logic v;
  pipe_t d, d_next;
  logic [32:0] trial;

  assign in_ready = !v || out_ready;

  always_comb begin
    trial = '0;
    d_next = in_d;
    for (int k = 0; k < 4; k++) begin
      trial = {1'b0, d_next.res} + {2'b0, d_next.sbit};
      if ({1'b0, d_next.rem} >= trial) begin
        d_next.rem = d_next.rem - trial[31:0];
        d_next.res = (d_next.res >> 1) + {1'b0, d_next.sbit};
      end else begin
        d_next.res = d_next.res >> 1;
      end
      d_next.sbit = d_next.sbit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= 1'b0;
    else if (in_ready) v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) d <= d_next;
  end

  assign out_valid = v;
  assign out_d = d;

endmodule

// ===== rtl/sad_speed.sv =====
// Sound speed scaling, Mach product and speed selection (five stages).
`timescale 1ns / 1ps
module sad_speed import sad_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  pipe_t       in_d,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] temperature,
  output logic [15:0] pressure,
  output logic [14:0] density,
  output logic [12:0] sound_speed,
  output logic [16:0] true_speed,
  output logic [1:0]  speed_status,
  output logic        altitude_clamped
);

  logic [4:0] v;
  logic [4:0] rdy;
  pipe_t d [5];
  pipe_t n [5];
  logic [24:0] sum_q;
  logic [15:0] q9;
  logic [13:0] q5;
  logic [29:0] tv_sum;
  logic [17:0] tvq;
  logic [16:0] tv;
  logic [1:0] st;

  assign rdy[4] = !v[4] || out_ready;
  assign rdy[3] = !v[3] || rdy[4];
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign in_ready = rdy[0];

  always_comb begin
    // s*401
    n[0] = in_d;
    n[0].acc = {18'd0, in_d.res[15:0]} * 34'd401;
    // (x + 1280) / 2560 = ((x + 1280) >> 9) / 5, /5 by reciprocal
    n[1] = d[0];
    sum_q = d[0].acc[24:0] + 25'd1280;
    q9 = sum_q[24:9];
    n[1].acc = {18'd0, q9} * 34'd209716;
    n[2] = d[1];
    q5 = d[1].acc[33:20];
    n[2].sound = q5[13] ? 13'h1FFF : q5[12:0];
    n[3] = d[2];
    n[3].acc = {21'd0, d[2].sound} * {18'd0, d[2].mach};
    n[4] = d[3];
  end

  always_comb begin
    tv_sum = {1'b0, d[3].acc[28:0]} + 30'd2048;
    tvq = tv_sum[29:12];
    tv = tvq[17] ? 17'h1FFFF : tvq[16:0];
    if (d[3].action == ACT_GIVEN) begin
      st = STAT_GIVEN;
      tv = d[3].given;
    end else if (d[3].action == ACT_MACH) begin
      st = STAT_MACH;
    end else begin
      st = STAT_INVALID;
      tv = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int i = 1; i < 5; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) d[0] <= n[0];
    for (int i = 1; i < 5; i++) begin
      if (rdy[i] && v[i-1]) d[i] <= n[i];
    end
    if (rdy[4] && v[3]) begin
      true_speed <= tv;
      speed_status <= st;
    end
  end

  assign out_valid = v[4];
  assign temperature = d[4].temp;
  assign pressure = d[4].press;
  assign density = d[4].dens;
  assign sound_speed = d[4].sound;
  assign altitude_clamped = d[4].clamped;

endmodule

// ===== rtl/standard_atmosphere_air_data.sv =====
// Top level of the standard atmosphere air data pipeline.
// Input channel: in_valid/in_ready with altitude (1/256 km), action,
// speed_given (1/16 m/s) and mach (Q4.12). Output channel: out_valid/
// out_ready with temperature, pressure, density, sound_speed, true_speed,
// speed_status and altitude_clamped, one result item per input item.
// Eleven register stages: two for the table lookup and interpolation,
// four for the 16-bit square root at four bits per stage, five for sound
// speed scaling and the Mach product. out_valid rises when the item
// reaches the last stage register. Throughput is one item per cycle
// while out_ready is high; each stage register holds its item until
// the next stage takes it.
// Reset clears all stage valid bits; no results are pending after reset.
// When the receiver stalls, the last stage holds its item and the stages
// behind it keep filling, so in_ready stays high until every stage is
// full. Altitudes above 20 km are clamped and flagged. Actions other than
// given speed or Mach return status invalid with zero true_speed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module standard_atmosphere_air_data import sad_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [12:0] altitude,
  input  logic [1:0]  action,
  input  logic [16:0] speed_given,
  input  logic [15:0] mach,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] temperature,
  output logic [15:0] pressure,
  output logic [14:0] density,
  output logic [12:0] sound_speed,
  output logic [16:0] true_speed,
  output logic [1:0]  speed_status,
  output logic        altitude_clamped
);

  logic [4:0] sv;
  logic [4:0] sr;
  pipe_t sd [5];
  logic status_ok;
  logic invalid_out;
  logic clamp_out;

  sad_lookup u_lookup (
    .clk, .rst, .in_valid, .in_ready, .altitude, .action, .speed_given, .mach,
    .out_valid(sv[0]), .out_ready(sr[0]), .out_d(sd[0])
  );

  for (genvar g = 0; g < 4; g++) begin : g_sqrt
    sad_sqrt u_sqrt (
      .clk, .rst,
      .in_valid(sv[g]), .in_ready(sr[g]), .in_d(sd[g]),
      .out_valid(sv[g+1]), .out_ready(sr[g+1]), .out_d(sd[g+1])
    );
  end

  sad_speed u_speed (
    .clk, .rst,
    .in_valid(sv[4]), .in_ready(sr[4]), .in_d(sd[4]),
    .out_valid, .out_ready, .temperature, .pressure, .density, .sound_speed,
    .true_speed, .speed_status, .altitude_clamped
  );

  assign status_ok = (speed_status == STAT_GIVEN) || (speed_status == STAT_MACH) ||
                     (speed_status == STAT_INVALID);
  assign invalid_out = out_valid && (speed_status == STAT_INVALID);
  assign clamp_out = out_valid && altitude_clamped;

  `SAD_ASSERT(a_status_code, clk, rst, out_valid |-> status_ok, "bad status")
  `SAD_ASSERT(a_invalid_zero, clk, rst, invalid_out |-> (true_speed == '0), "invalid with speed")
  `SAD_ASSERT(a_clamp_temp, clk, rst, clamp_out |-> (temperature == TEMP_TOP), "clamp not at top")
  `SAD_ASSERT_NR(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

endmodule
